FILE: sv/dead_pad_mask_map_unit_macros.svh
// Assertion macros shared by the pad mask map modules.
`ifndef DEAD_PAD_MASK_MAP_UNIT_MACROS_SVH
`define DEAD_PAD_MASK_MAP_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication on every clock edge outside reset.
`define DPM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define DPM_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) else $error(msg);

`else

`define DPM_ASSERT(lbl, clk, rstn, prop, msg)

`define DPM_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg)

`endif

`endif

FILE: sv/dpm_pkg.sv
// Types, constants and helper functions of the pad mask map.
package dpm_pkg;

  localparam int PADS_X     = 160;
  localparam int PADS_Y     = 144;
  localparam int CHAMBERS   = 7;
  localparam int PC_PADS_X  = 80;
  localparam int PC_PADS_Y  = 48;
  localparam int SECTORS    = 6;
  localparam int PC_COUNT   = 6;

  localparam int WORD_BITS     = 48;
  localparam int WORDS_PER_COL = (PADS_Y + WORD_BITS - 1) / WORD_BITS;
  localparam int CH_WORDS      = PADS_X * WORDS_PER_COL;
  localparam int WORD_COUNT    = CHAMBERS * CH_WORDS;
  localparam int ADDR_W        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W         = $clog2(WORD_BITS);
  localparam int WIDX_W        = (WORDS_PER_COL > 1) ? $clog2(WORDS_PER_COL) : 1;
  localparam int SECT_ROWS     = PADS_Y / SECTORS;

  // Column and row bounds of a region, wide enough for clipped block edges.
  localparam int X_W = $clog2(PADS_X + 2 * PC_PADS_X + 1);
  localparam int Y_W = $clog2(PADS_Y + 3 * PC_PADS_Y + 1);

  localparam int COORD_W      = 8;
  localparam int MAX_ROW_WORD = ((1 << COORD_W) - 1) / WORD_BITS;
  localparam int ROW_WORD_W   = (MAX_ROW_WORD > 0) ? $clog2(MAX_ROW_WORD + 1) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_QUERY       = 2'd0,
    CMD_SET_CHAMBER = 2'd1,
    CMD_SET_SECTOR  = 2'd2,
    CMD_SET_PC      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    JOB_NOP,
    JOB_QUERY,
    JOB_WRITE
  } job_kind_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         chamber;
    logic [2:0]         sector;
    logic [2:0]         cathode;
    logic [COORD_W-1:0] pad_col;
    logic [COORD_W-1:0] pad_row;
    logic               active;
  } in_req_t;

  typedef struct packed {
    logic       pad_dead;
    logic [1:0] op_done;
  } out_res_t;

  // Classified request handed from the front end to the engine.
  typedef struct packed {
    job_kind_t         kind;
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] addr;
    logic [BIT_W-1:0]  bit_idx;
    logic [X_W-1:0]    ncols;
    logic [Y_W-1:0]    y0;
    logic [Y_W-1:0]    y1;
    logic              on;
  } job_t;

  // Word of a column that holds a given pad row.
  function automatic logic [ROW_WORD_W-1:0] row_word(logic [COORD_W-1:0] row);
    int n;
    n = 0;
    for (int k = 1; k <= MAX_ROW_WORD; k++) begin
      if (int'(row) >= k * WORD_BITS) n++;
    end
    return ROW_WORD_W'(n);
  endfunction

endpackage

FILE: sv/dpm_front.sv
// Front end: accepts requests, range checks them and turns them into jobs.
module dpm_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  dpm_pkg::in_req_t in_req,
  input  logic            q_full,
  input  logic            clr_busy,
  output logic            push,
  output dpm_pkg::job_t   push_job
);

  always_comb begin
    int   x0_i;
    int   x1_i;
    int   y0_i;
    int   y1_i;
    int   col_i;
    int   rw_i;
    logic ch_ok;
    logic region_ok;

    ch_ok     = int'(in_req.chamber) < dpm_pkg::CHAMBERS;
    region_ok = 1'b0;
    x0_i      = 0;
    x1_i      = 0;
    y0_i      = 0;
    y1_i      = 0;
    col_i     = 0;
    rw_i      = 0;

    push_job         = '0;
    push_job.kind    = dpm_pkg::JOB_NOP;
    push_job.cmd     = in_req.cmd;
    push_job.on      = in_req.active;

    unique case (in_req.cmd)
      dpm_pkg::CMD_QUERY: begin
        if (ch_ok && int'(in_req.pad_col) < dpm_pkg::PADS_X &&
            int'(in_req.pad_row) < dpm_pkg::PADS_Y) begin
          push_job.kind = dpm_pkg::JOB_QUERY;
        end
        col_i = int'(in_req.pad_col);
        rw_i  = int'(dpm_pkg::row_word(in_req.pad_row));
        push_job.bit_idx = dpm_pkg::BIT_W'(int'(in_req.pad_row) - rw_i * dpm_pkg::WORD_BITS);
      end
      dpm_pkg::CMD_SET_CHAMBER: begin
        region_ok = 1'b1;
        x1_i      = dpm_pkg::PADS_X;
        y1_i      = dpm_pkg::PADS_Y;
      end
      dpm_pkg::CMD_SET_SECTOR: begin
        region_ok = int'(in_req.sector) < dpm_pkg::SECTORS;
        y0_i      = int'(in_req.sector) * dpm_pkg::SECT_ROWS;
        x1_i      = dpm_pkg::PADS_X;
        y1_i      = y0_i + dpm_pkg::SECT_ROWS;
      end
      dpm_pkg::CMD_SET_PC: begin
        region_ok = int'(in_req.cathode) < dpm_pkg::PC_COUNT;
        x0_i      = int'(in_req.cathode[0]) * dpm_pkg::PC_PADS_X;
        y0_i      = int'(in_req.cathode[2:1]) * dpm_pkg::PC_PADS_Y;
        x1_i      = x0_i + dpm_pkg::PC_PADS_X;
        y1_i      = y0_i + dpm_pkg::PC_PADS_Y;
        // clip the block at the chamber edge
        if (x1_i > dpm_pkg::PADS_X) x1_i = dpm_pkg::PADS_X;
        if (y1_i > dpm_pkg::PADS_Y) y1_i = dpm_pkg::PADS_Y;
      end
    endcase

    if (in_req.cmd != dpm_pkg::CMD_QUERY) begin
      col_i = x0_i;
      if (ch_ok && region_ok && x0_i < x1_i && y0_i < y1_i) begin
        push_job.kind  = dpm_pkg::JOB_WRITE;
        push_job.ncols = dpm_pkg::X_W'(x1_i - x0_i);
        push_job.y0    = dpm_pkg::Y_W'(y0_i);
        push_job.y1    = dpm_pkg::Y_W'(y1_i);
      end
    end

    push_job.addr = dpm_pkg::ADDR_W'(int'(in_req.chamber) * dpm_pkg::CH_WORDS +
                                     col_i * dpm_pkg::WORDS_PER_COL + rw_i);
  end

  assign in_stall = q_full | clr_busy;
  assign push     = in_valid & ~in_stall;

endmodule

FILE: sv/dpm_queue.sv
// Short job queue between the front end and the engine.
`include "dead_pad_mask_map_unit_macros.svh"

module dpm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dpm_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output dpm_pkg::job_t pop_job,
  output logic          empty
);

  dpm_pkg::job_t                 slot_r [dpm_pkg::QUEUE_DEPTH];
  logic [dpm_pkg::Q_PTR_W-1:0]   wr_ptr_r;
  logic [dpm_pkg::Q_PTR_W-1:0]   rd_ptr_r;
  logic [dpm_pkg::Q_CNT_W-1:0]   cnt_r;

  assign full    = (cnt_r == dpm_pkg::Q_CNT_W'(dpm_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == dpm_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == dpm_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  `DPM_ASSERT(a_q_no_overflow, clk, rst_n, push |-> !full, "job pushed into a full queue")
  `DPM_ASSERT(a_q_no_underflow, clk, rst_n, pop |-> !empty, "job popped from an empty queue")
  `DPM_ASSERT_NEXT(a_q_count_up, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "queue count did not advance on push")

endmodule

FILE: sv/dpm_back.sv
// Engine: owns the pad status memory and runs queries and region writes.
`include "dead_pad_mask_map_unit_macros.svh"

module dpm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  dpm_pkg::job_t     q_job,
  output logic              pop,
  output logic              clr_busy,
  output logic              out_valid,
  input  logic              out_stall,
  output dpm_pkg::out_res_t out_res
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_Q_RD,
    ST_Q_DATA,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t                           state_r;
  dpm_pkg::job_t                    job_r;
  logic [dpm_pkg::ADDR_W-1:0]       addr_r;
  logic [dpm_pkg::X_W-1:0]          cols_left_r;
  logic [dpm_pkg::WIDX_W-1:0]       word_r;
  logic [dpm_pkg::Y_W-1:0]          row_base_r;
  logic                             dead_r;
  logic                             wr_vld_r;
  logic [dpm_pkg::ADDR_W-1:0]       wr_addr_r;
  logic [dpm_pkg::WORD_BITS-1:0]    wr_mask_r;
  logic                             out_valid_r;
  dpm_pkg::out_res_t                out_res_r;

  logic [dpm_pkg::WORD_BITS-1:0]    pad_mem_r [dpm_pkg::WORD_COUNT];
  logic [dpm_pkg::WORD_BITS-1:0]    mem_q_r;

  logic                             mem_we;
  logic [dpm_pkg::ADDR_W-1:0]       mem_waddr;
  logic [dpm_pkg::WORD_BITS-1:0]    mem_wdata;
  logic [dpm_pkg::WORD_BITS-1:0]    mask_c;

  assign pop       = (state_r == ST_IDLE) && !q_empty;
  assign clr_busy  = (state_r == ST_CLEAR);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Rows of the current word that fall inside the region.
  always_comb begin
    logic [dpm_pkg::Y_W:0] row_i;
    for (int i = 0; i < dpm_pkg::WORD_BITS; i++) begin
      row_i     = {1'b0, row_base_r} + (dpm_pkg::Y_W + 1)'(i);
      mask_c[i] = (row_i >= {1'b0, job_r.y0}) && (row_i < {1'b0, job_r.y1});
    end
  end

  // Write port: clearing pass or the write half of a read-modify-write.
  always_comb begin
    mem_we    = clr_busy | wr_vld_r;
    mem_waddr = clr_busy ? addr_r : wr_addr_r;
    if (clr_busy) begin
      mem_wdata = '1;
    end else if (job_r.on) begin
      mem_wdata = mem_q_r | wr_mask_r;
    end else begin
      mem_wdata = mem_q_r & ~wr_mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) pad_mem_r[mem_waddr] <= mem_wdata;
    mem_q_r <= pad_mem_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      wr_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // the write half follows every walk cycle
      wr_vld_r    <= (state_r == ST_WALK);
      // raise on a new result, hold while stalled, drop once taken
      out_valid_r <= (state_r == ST_RESULT) || (out_valid_r && out_stall);

      unique case (state_r)
        ST_CLEAR: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == dpm_pkg::ADDR_W'(dpm_pkg::WORD_COUNT - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (!q_empty) begin
            job_r       <= q_job;
            addr_r      <= q_job.addr;
            cols_left_r <= q_job.ncols;
            word_r      <= '0;
            row_base_r  <= '0;
            dead_r      <= 1'b0;
            unique case (q_job.kind)
              dpm_pkg::JOB_QUERY: state_r <= ST_Q_RD;
              dpm_pkg::JOB_WRITE: state_r <= ST_WALK;
              default:            state_r <= ST_RESULT;
            endcase
          end
        end
        ST_Q_RD: begin
          state_r <= ST_Q_DATA;
        end
        ST_Q_DATA: begin
          dead_r  <= ~mem_q_r[job_r.bit_idx];
          state_r <= ST_RESULT;
        end
        ST_WALK: begin
          // issue the read now, write the merged word next cycle
          wr_addr_r <= addr_r;
          wr_mask_r <= mask_c;
          addr_r    <= addr_r + 1'b1;
          if (word_r == dpm_pkg::WIDX_W'(dpm_pkg::WORDS_PER_COL - 1)) begin
            word_r      <= '0;
            row_base_r  <= '0;
            cols_left_r <= cols_left_r - 1'b1;
            if (cols_left_r == dpm_pkg::X_W'(1)) state_r <= ST_DRAIN;
          end else begin
            word_r     <= word_r + 1'b1;
            row_base_r <= row_base_r + dpm_pkg::Y_W'(dpm_pkg::WORD_BITS);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_valid_r || !out_stall) begin
            out_res_r.pad_dead <= dead_r;
            out_res_r.op_done  <= job_r.cmd;
            state_r            <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `DPM_ASSERT(a_result_after_drain, clk, rst_n, (state_r == ST_RESULT) |-> !wr_vld_r, "result raised with a write still in flight")
  `DPM_ASSERT(a_no_result_in_clear, clk, rst_n, (state_r == ST_CLEAR) |-> !out_valid_r, "result present during the clearing pass")
  `DPM_ASSERT(a_write_not_dead, clk, rst_n, (state_r == ST_RESULT && job_r.kind != dpm_pkg::JOB_QUERY) |-> !dead_r, "dead flag set for a non-query request")

endmodule

FILE: sv/dead_pad_mask_map_unit.sv
// Top level of the pad active/dead mask map.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-------------------------------------
//   in_     | request   | in_valid/in_stall | dpm_pkg::in_req_t (cmd, region, pad)
//   out_    | result    | out_valid/out_st. | dpm_pkg::out_res_t (pad_dead, op_done)
//
// After reset the engine sweeps all WORD_COUNT (3360) words of the status memory to
// all ones, one 48-bit word a cycle; in_stall stays high during the sweep. A query
// goes from the queue through ST_Q_RD and ST_Q_DATA to ST_RESULT, an out-of-range
// request straight to ST_RESULT. A region write walks WORDS_PER_COL words per column,
// one read-modify-write a cycle; chamber and sector span 160 columns, photocathode 80.
// The 2-deep queue keeps accepting while the engine works; in_stall rises when full.
module dead_pad_mask_map_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dpm_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output dpm_pkg::out_res_t out_res
);

  logic          push;
  dpm_pkg::job_t push_job;
  logic          q_full;
  logic          q_empty;
  logic          pop;
  dpm_pkg::job_t pop_job;
  logic          clr_busy;

  // Classify and range check each request; out-of-range work becomes a no-op.
  dpm_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_full   (q_full),
    .clr_busy (clr_busy),
    .push     (push),
    .push_job (push_job)
  );

  // Hold decoded jobs so intake and execution stall independently.
  dpm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // Run queries and region writes against the status memory.
  dpm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .pop       (pop),
    .clr_busy  (clr_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule
